/* rtl/ialu_pkg.sv */
package ialu_pkg;

    localparam int DATA_W_DEF = 32;
    localparam int FRAC_W_DEF = 8;
    localparam int OPND_W     = 32;
    localparam int OUT_W      = 40;
    localparam int FUNC_W     = 3;
    localparam int ERR_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_SUB    = 3'd1,
        FN_MUL    = 3'd2,
        FN_DIV    = 3'd3,
        FN_SQUARE = 3'd4,
        FN_SQRT   = 3'd5
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_NEG_SQRT = 2'd2,
        ERR_INVALID  = 2'd3
    } t_err;

    // which datapath supplies the result at the end of the chain
    typedef enum logic [1:0] {
        RS_INT  = 2'd0,
        RS_DIV  = 2'd1,
        RS_SQRT = 2'd2
    } t_rsel;

    typedef struct packed {
        t_rsel sel;
        t_err  err;
        logic  q_neg;
    } t_ctl;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [OPND_W-1:0] operand_a;
        logic signed [OPND_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] result_value;
        logic                    result_is_fixed;
        logic [ERR_W-1:0]        error_code;
    } t_out;

endpackage

/* rtl/ialu_front.sv */
module ialu_front #(
    parameter int DW = 32,
    parameter int FB = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  ialu_pkg::t_in   i_data,
    output logic            o_vld,
    output ialu_pkg::t_ctl  o_ctl,
    output logic [DW-1:0]   o_int,
    output logic [DW-1:0]   o_ub,
    output logic [DW+FB-1:0] o_dq,
    output logic [2*((DW+2*FB+1)/2)-1:0] o_m
);
    import ialu_pkg::*;

    localparam int L  = DW + FB;
    localparam int RW = (DW + 2 * FB + 1) / 2;
    localparam int M2 = 2 * RW;

    logic [DW-1:0]   a_d;
    logic [DW-1:0]   b_d;
    logic [DW-1:0]   ua;
    logic [DW-1:0]   ub;
    logic [DW-1:0]   mb;
    logic [DW-1:0]   prod;

    logic            r_vld;
    t_ctl            r_ctl, n_ctl;
    logic [DW-1:0]   r_int, n_int;
    logic [DW-1:0]   r_ub;
    logic [L-1:0]    r_dq;
    logic [M2-1:0]   r_m;

    assign a_d  = i_data.operand_a[DW-1:0];
    assign b_d  = i_data.operand_b[DW-1:0];
    assign ua   = a_d[DW-1] ? (~a_d + 1'b1) : a_d;
    assign ub   = b_d[DW-1] ? (~b_d + 1'b1) : b_d;
    // one multiplier shared by multiply and square
    assign mb   = (t_func'(i_data.func) == FN_SQUARE) ? a_d : b_d;
    assign prod = a_d * mb;

    always_comb begin
        n_int       = '0;
        n_ctl.sel   = RS_INT;
        n_ctl.err   = ERR_NONE;
        n_ctl.q_neg = a_d[DW-1] ^ b_d[DW-1];
        case (t_func'(i_data.func))
            FN_ADD: begin
                n_int = a_d + b_d;
            end
            FN_SUB: begin
                n_int = a_d - b_d;
            end
            FN_MUL, FN_SQUARE: begin
                n_int = prod;
            end
            FN_DIV: begin
                n_ctl.sel = RS_DIV;
                if (b_d == '0) begin
                    n_ctl.err = ERR_DIV_ZERO;
                end
            end
            FN_SQRT: begin
                n_ctl.sel = RS_SQRT;
                if (a_d[DW-1]) begin
                    n_ctl.err = ERR_NEG_SQRT;
                end
            end
            default: begin
                n_ctl.err = ERR_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_int <= n_int;
            r_ub  <= ub;
            r_dq  <= L'(ua) << FB;
            r_m   <= M2'(ua) << (2 * FB);
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_int = r_int;
    assign o_ub  = r_ub;
    assign o_dq  = r_dq;
    assign o_m   = r_m;

endmodule

/* rtl/ialu_cell.sv */
module ialu_cell #(
    parameter int DW      = 32,
    parameter int FB      = 8,
    parameter bit SQRT_EN = 1'b1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  ialu_pkg::t_ctl  i_ctl,
    input  logic [DW-1:0]   i_int,
    input  logic [DW-1:0]   i_ub,
    input  logic [DW-1:0]   i_rem,
    input  logic [DW+FB-1:0] i_dq,
    input  logic [2*((DW+2*FB+1)/2)-1:0] i_m,
    input  logic [(DW+2*FB+1)/2+1:0]     i_srem,
    input  logic [(DW+2*FB+1)/2-1:0]     i_root,
    output logic            o_vld,
    output ialu_pkg::t_ctl  o_ctl,
    output logic [DW-1:0]   o_int,
    output logic [DW-1:0]   o_ub,
    output logic [DW-1:0]   o_rem,
    output logic [DW+FB-1:0] o_dq,
    output logic [2*((DW+2*FB+1)/2)-1:0] o_m,
    output logic [(DW+2*FB+1)/2+1:0]     o_srem,
    output logic [(DW+2*FB+1)/2-1:0]     o_root
);
    import ialu_pkg::*;

    localparam int L  = DW + FB;
    localparam int RW = (DW + 2 * FB + 1) / 2;
    localparam int M2 = 2 * RW;

    logic [DW:0]   div_sh;
    logic [DW:0]   div_diff;
    logic          div_ge;
    logic [RW+1:0] s_sh;
    logic [RW+1:0] s_trial;
    logic [RW+2:0] s_diff;
    logic          s_ge;

    logic          r_vld;
    t_ctl          r_ctl;
    logic [DW-1:0] r_int;
    logic [DW-1:0] r_ub;
    logic [DW-1:0] r_rem, n_rem;
    logic [L-1:0]  r_dq, n_dq;
    logic [M2-1:0] r_m, n_m;
    logic [RW+1:0] r_srem, n_srem;
    logic [RW-1:0] r_root, n_root;

    // restoring divide: one quotient bit, shifted into the low end of dq
    assign div_sh   = {i_rem, i_dq[L-1]};
    assign div_diff = div_sh - {1'b0, i_ub};
    assign div_ge   = !div_diff[DW];
    assign n_rem    = div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
    assign n_dq     = {i_dq[L-2:0], div_ge};

    // digit-by-digit square root: one root bit from two radicand bits
    assign s_sh    = {i_srem[RW-1:0], i_m[M2-1:M2-2]};
    assign s_trial = {i_root, 2'b01};
    assign s_diff  = {1'b0, s_sh} - {1'b0, s_trial};
    assign s_ge    = !s_diff[RW+2];

    always_comb begin
        if (SQRT_EN) begin
            n_srem = s_ge ? s_diff[RW+1:0] : s_sh;
            n_root = {i_root[RW-2:0], s_ge};
            n_m    = i_m << 2;
        end else begin
            n_srem = i_srem;
            n_root = i_root;
            n_m    = i_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl  <= i_ctl;
            r_int  <= i_int;
            r_ub   <= i_ub;
            r_rem  <= n_rem;
            r_dq   <= n_dq;
            r_m    <= n_m;
            r_srem <= n_srem;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_ctl  = r_ctl;
    assign o_int  = r_int;
    assign o_ub   = r_ub;
    assign o_rem  = r_rem;
    assign o_dq   = r_dq;
    assign o_m    = r_m;
    assign o_srem = r_srem;
    assign o_root = r_root;

endmodule

/* rtl/integer_alu_with_div_sqrt_unit.sv */
// Signed integer ALU: add, sub, multiply and square wrap to DATA_WIDTH bits and come out
// sign-extended; divide and square root come out as fixed point with FRAC_BITS fractional
// bits, truncated, with divide by zero and negative square root giving zero and an error
// code. One transaction is taken every cycle while o_stall is low. The pipeline is a front
// register, a chain of DATA_WIDTH + FRAC_BITS cells, each of which produces one quotient
// bit, and an output register; the first (DATA_WIDTH + 2 * FRAC_BITS + 1) / 2 cells (24 with
// the defaults) also produce one square root bit each. While a valid result is held by
// i_stall the whole pipeline holds and o_stall is raised.
module integer_alu_with_div_sqrt_unit #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_W_DEF,
    parameter int FRAC_BITS  = ialu_pkg::FRAC_W_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ialu_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ialu_pkg::t_out  o_data
);
    import ialu_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int L  = DW + FB;
    localparam int RW = (DW + 2 * FB + 1) / 2;
    localparam int M2 = 2 * RW;
    localparam int SW = (L > OUT_W) ? OUT_W : L;
    localparam int XW = ((L > OUT_W) ? L : OUT_W) + 1;
    localparam logic [XW-1:0] NEG_MAG = XW'(64'd1 << (SW - 1));
    localparam logic [XW-1:0] POS_LIM = XW'((64'd1 << (SW - 1)) - 64'd1);

    logic          en;
    logic          c_vld  [0:L];
    t_ctl          c_ctl  [0:L];
    logic [DW-1:0] c_int  [0:L];
    logic [DW-1:0] c_ub   [0:L];
    logic [DW-1:0] c_rem  [0:L];
    logic [L-1:0]  c_dq   [0:L];
    logic [M2-1:0] c_m    [0:L];
    logic [RW+1:0] c_srem [0:L];
    logic [RW-1:0] c_root [0:L];

    logic [XW-1:0] qx;
    logic [XW-1:0] q_neg_mag;
    logic [XW-1:0] q_neg_val;
    logic [XW-1:0] q_pos_val;
    logic [OUT_W-1:0] div_val;
    t_ctl          last_ctl;

    logic          r_vld;
    t_out          r_out, n_out;

    assign en      = !r_vld || !i_stall;
    assign o_stall = !en;

    ialu_front #(.DW(DW), .FB(FB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_data  (i_data),
        .o_vld   (c_vld[0]),
        .o_ctl   (c_ctl[0]),
        .o_int   (c_int[0]),
        .o_ub    (c_ub[0]),
        .o_dq    (c_dq[0]),
        .o_m     (c_m[0])
    );

    assign c_rem[0]  = '0;
    assign c_srem[0] = '0;
    assign c_root[0] = '0;

    for (genvar k = 0; k < L; k++) begin : g_cell
        ialu_cell #(
            .DW      (DW),
            .FB      (FB),
            .SQRT_EN ((k < RW) ? 1'b1 : 1'b0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[k]),
            .i_ctl   (c_ctl[k]),
            .i_int   (c_int[k]),
            .i_ub    (c_ub[k]),
            .i_rem   (c_rem[k]),
            .i_dq    (c_dq[k]),
            .i_m     (c_m[k]),
            .i_srem  (c_srem[k]),
            .i_root  (c_root[k]),
            .o_vld   (c_vld[k+1]),
            .o_ctl   (c_ctl[k+1]),
            .o_int   (c_int[k+1]),
            .o_ub    (c_ub[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_dq    (c_dq[k+1]),
            .o_m     (c_m[k+1]),
            .o_srem  (c_srem[k+1]),
            .o_root  (c_root[k+1])
        );
    end

    // quotient magnitude to signed, saturated to SW bits
    assign last_ctl  = c_ctl[L];
    assign qx        = XW'(c_dq[L]);
    assign q_neg_mag = (qx > NEG_MAG) ? NEG_MAG : qx;
    assign q_neg_val = ~q_neg_mag + 1'b1;
    assign q_pos_val = (qx > POS_LIM) ? POS_LIM : qx;
    assign div_val   = last_ctl.q_neg ? q_neg_val[OUT_W-1:0] : q_pos_val[OUT_W-1:0];

    always_comb begin
        n_out.result_is_fixed = (last_ctl.sel != RS_INT);
        n_out.error_code      = last_ctl.err;
        case (last_ctl.sel)
            RS_INT: begin
                n_out.result_value = {{(OUT_W - DW){c_int[L][DW-1]}}, c_int[L]};
            end
            RS_DIV: begin
                n_out.result_value = div_val;
            end
            RS_SQRT: begin
                n_out.result_value = OUT_W'(c_root[L]);
            end
            default: begin
                n_out.result_value = '0;
            end
        endcase
        if (last_ctl.err != ERR_NONE) begin
            n_out.result_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= c_vld[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.error_code != ERR_NONE) |-> (o_data.result_value == '0))
        else $error("error transaction carries a nonzero value");

    a_fixed_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_data.error_code == ERR_DIV_ZERO) || (o_data.error_code == ERR_NEG_SQRT))
        |-> o_data.result_is_fixed)
        else $error("divide or sqrt error not flagged as fixed point");

    a_invalid_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.error_code == ERR_INVALID) |-> !o_data.result_is_fixed)
        else $error("invalid function flagged as fixed point");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(c_vld[L]))
        else $error("pipeline moved while output stalled");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ialu_pkg::*;

    localparam int FRAC = FRAC_W_DEF;
    localparam int SAT_W = (DATA_W_DEF + FRAC_W_DEF > OUT_W) ? OUT_W : DATA_W_DEF + FRAC_W_DEF;
    localparam int RANDOM_OPS = 800;
    localparam int DRAIN_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int LONG_HOLD_AFTER = 300;
    localparam int REPORT_LIMIT = 10;

    // function codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    localparam logic signed [OPND_W-1:0] OPND_MAX = 32'sh7fff_ffff;
    localparam logic signed [OPND_W-1:0] OPND_MIN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    t_in queued_ops[$];
    t_out awaited_results[$];

    int failures = 0;
    int results_seen = 0;
    int send_gap = 0;
    int send_burst = 0;
    int hold_left = 0;
    int recv_burst = 0;
    bit long_hold_done = 1'b0;
    int idle_cycles = 0;

    integer_alu_with_div_sqrt_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out alu_result(input t_in op);
        t_out r;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
        logic signed [OPND_W-1:0] wrapped;
        longint quot;
        longint sat_hi;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned step_v;
        r = '0;
        a = op.operand_a;
        b = op.operand_b;
        sat_hi = (64'sd1 <<< (SAT_W - 1)) - 1;
        case (op.func)
            FN_ADD: begin
                wrapped = a + b;
                r.result_value = OUT_W'(wrapped);
            end
            FN_SUB: begin
                wrapped = a - b;
                r.result_value = OUT_W'(wrapped);
            end
            FN_MUL: begin
                wrapped = a * b;
                r.result_value = OUT_W'(wrapped);
            end
            FN_SQUARE: begin
                wrapped = a * a;
                r.result_value = OUT_W'(wrapped);
            end
            FN_DIV: begin
                r.result_is_fixed = 1'b1;
                if (b == 0) begin
                    r.error_code = ERR_DIV_ZERO;
                end else begin
                    // signed division truncates toward zero
                    quot = (longint'(a) * (64'sd1 <<< FRAC)) / longint'(b);
                    if (quot > sat_hi) quot = sat_hi;
                    if (quot < -sat_hi - 1) quot = -sat_hi - 1;
                    r.result_value = quot[OUT_W-1:0];
                end
            end
            FN_SQRT: begin
                r.result_is_fixed = 1'b1;
                if (a < 0) begin
                    r.error_code = ERR_NEG_SQRT;
                end else begin
                    // floor(sqrt(a) * 2^frac) as an integer root of a * 2^(2*frac)
                    rad = longint'(a) << (2 * FRAC);
                    root = 0;
                    step_v = 64'd1 << 62;
                    while (step_v > rad) step_v >>= 2;
                    while (step_v != 0) begin
                        if (rad >= root + step_v) begin
                            rad -= root + step_v;
                            root = (root >> 1) + step_v;
                        end else begin
                            root >>= 1;
                        end
                        step_v >>= 2;
                    end
                    r.result_value = root[OUT_W-1:0];
                end
            end
            default: begin
                r.error_code = ERR_INVALID;
            end
        endcase
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones, now and then a run with none
    function automatic int idle_length(inout int burst_left);
        int roll;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [OPND_W-1:0] rand_operand();
        logic signed [OPND_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom();
            3, 4: begin
                case ($urandom_range(0, 4))
                    0: v = 0;
                    1: v = 1;
                    2: v = -1;
                    3: v = OPND_MAX;
                    default: v = OPND_MIN;
                endcase
            end
            5, 6, 7: v = $urandom_range(0, 600) - 300;
            default: begin
                v = $urandom();
                v = v >>> $urandom_range(1, 30);
            end
        endcase
        return v;
    endfunction

    task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic signed [OPND_W-1:0] a,
                            input logic signed [OPND_W-1:0] b);
        t_in op;
        op.func = fn;
        op.operand_a = a;
        op.operand_b = b;
        queued_ops.push_back(op);
    endtask

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_ops
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) awaited_results.push_back(alu_result(i_data));
            if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (queued_ops.size() != 0) begin
                i_data <= queued_ops.pop_front();
                i_valid <= 1'b1;
                send_gap = idle_length(send_burst);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin : check_results
        t_out want;
        int n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_failure($sformatf(
                        "result with nothing outstanding: value %0d fixed %b err %0d",
                        o_data.result_value, o_data.result_is_fixed, o_data.error_code));
                end else begin
                    want = awaited_results.pop_front();
                    if (o_data.result_value !== want.result_value
                        || o_data.result_is_fixed !== want.result_is_fixed
                        || o_data.error_code !== want.error_code) begin
                        report_failure({
                            $sformatf("result %0d: expected value %0d fixed %b err %0d,",
                                      results_seen, want.result_value,
                                      want.result_is_fixed, want.error_code),
                            $sformatf(" got value %0d fixed %b err %0d",
                                      o_data.result_value, o_data.result_is_fixed,
                                      o_data.error_code)});
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
                // long back-pressure so the pipeline fills and stalls the sender
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                n = idle_length(recv_burst);
                if (n != 0) hold_left = n - 1;
                i_stall <= (n != 0);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [FUNC_W-1:0] fn;
        int roll;

        // wrap on add, sub, mul and square
        queue_op(FN_ADD, OPND_MAX, OPND_MAX);
        queue_op(FN_ADD, OPND_MIN, OPND_MIN);
        queue_op(FN_SUB, OPND_MIN, 1);
        queue_op(FN_SUB, OPND_MAX, OPND_MIN);
        queue_op(FN_MUL, OPND_MAX, OPND_MAX);
        queue_op(FN_MUL, OPND_MIN, -1);
        queue_op(FN_MUL, -3, 7);
        queue_op(FN_SQUARE, OPND_MIN, 0);
        queue_op(FN_SQUARE, OPND_MAX, 0);
        queue_op(FN_SQUARE, -46341, 0);
        // divide: saturation, zero divisor, truncation toward zero
        queue_op(FN_DIV, OPND_MIN, -1);
        queue_op(FN_DIV, 5, 0);
        queue_op(FN_DIV, 0, 0);
        queue_op(FN_DIV, -7, 2);
        queue_op(FN_DIV, 1, OPND_MAX);
        queue_op(FN_DIV, -1, OPND_MAX);
        queue_op(FN_DIV, OPND_MAX, 1);
        queue_op(FN_DIV, OPND_MIN, OPND_MAX);
        // square root: zero, one, irrational, largest, negatives
        queue_op(FN_SQRT, 0, 0);
        queue_op(FN_SQRT, 1, 0);
        queue_op(FN_SQRT, 2, 0);
        queue_op(FN_SQRT, OPND_MAX, 0);
        queue_op(FN_SQRT, -1, 0);
        queue_op(FN_SQRT, OPND_MIN, OPND_MAX);
        // codes with no operation
        queue_op(FN_RSVD_6, OPND_MAX, OPND_MIN);
        queue_op(FN_RSVD_7, -1, -1);

        repeat (RANDOM_OPS) begin
            roll = $urandom_range(0, 19);
            if (roll < 19) fn = FUNC_W'(roll % 6);
            else fn = FUNC_W'($urandom_range(FN_RSVD_6, FN_RSVD_7));
            queue_op(fn, rand_operand(), rand_operand());
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (queued_ops.size() != 0 || i_valid || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0)
            report_failure($sformatf("%0d results never arrived", awaited_results.size()));
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ialu_pkg.sv
rtl/ialu_front.sv
rtl/ialu_cell.sv
rtl/integer_alu_with_div_sqrt_unit.sv
verif/tb.sv
